// File: design/sm3h_pkg.sv
// ----------------------------------------------------------------------------
// SM3 hash package
// Shared types, constants and round functions of the SM3 hash unit.
// ----------------------------------------------------------------------------
package sm3h_pkg;

  // Initial chaining value words.
  localparam logic [31:0] IV0 = 32'h7380166f;
  localparam logic [31:0] IV1 = 32'h4914b2b9;
  localparam logic [31:0] IV2 = 32'h172442d7;
  localparam logic [31:0] IV3 = 32'hda8a0600;
  localparam logic [31:0] IV4 = 32'ha96f30bc;
  localparam logic [31:0] IV5 = 32'h163138aa;
  localparam logic [31:0] IV6 = 32'he38dee4d;
  localparam logic [31:0] IV7 = 32'hb0fb0e4e;

  // Round constants for rounds 0..15 and 16..63.
  localparam logic [31:0] TJ_LO = 32'h79cc4519;
  localparam logic [31:0] TJ_HI = 32'h7a879d8a;

  // Block command from the front part to the compression engine.
  typedef struct packed {
    logic [15:0][31:0] blk;   // sixteen message words, word 0 first
    logic              fin;   // last block of a message: emit digest after it
  } blk_cmd_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

endpackage

// File: design/sm3h_front.sv
// ----------------------------------------------------------------------------
// SM3 front end
// Collects message words into 64-byte blocks, appends the padding and the
// bit length on the last word, and hands whole blocks to the block queue.
// ----------------------------------------------------------------------------
module sm3h_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [31:0]         in_msg_word,
  input  logic [2:0]          in_word_bytes,
  input  logic                in_last_word,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output sm3h_pkg::blk_cmd_t  cmd
);
  import sm3h_pkg::*;

  // Padding phases after the last word.
  localparam logic [1:0] PH_COLLECT = 2'd0;
  localparam logic [1:0] PH_EXTRA   = 2'd1;

  logic [1:0]        phase_r, phase_nxt;
  logic [15:0][31:0] buf_r, buf_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [63:0]       mbytes_r, mbytes_nxt;
  logic              cmd_valid_r, cmd_valid_nxt;
  blk_cmd_t          cmd_r, cmd_nxt;

  logic        acc;
  logic [2:0]  nb;
  logic [31:0] wmask;
  logic [6:0]  fill;
  logic [63:0] mb_upd;
  logic [63:0] bits;
  logic [15:0][31:0] lb;
  logic [31:0] mark;

  // Bit length kept for the extra block.
  logic [31:0] bits_hold_hi, bits_hold_lo;
  logic [63:0] bits_r;

  // One pending block output; no input while it waits or while padding runs.
  assign in_full   = cmd_valid_r || (phase_r != PH_COLLECT);
  assign acc       = in_push && !in_full;
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    phase_nxt     = phase_r;
    buf_nxt       = buf_r;
    idx_nxt       = idx_r;
    mbytes_nxt    = mbytes_r;
    cmd_valid_nxt = cmd_valid_r && !cmd_ready;
    cmd_nxt       = cmd_r;
    nb            = (in_word_bytes > 3'd4) ? 3'd4 : in_word_bytes;
    unique case (nb)
      3'd0:    wmask = 32'h0;
      3'd1:    wmask = 32'hff000000;
      3'd2:    wmask = 32'hffff0000;
      3'd3:    wmask = 32'hffffff00;
      default: wmask = 32'hffffffff;
    endcase
    mb_upd = mbytes_r + {61'd0, nb};
    bits   = {mb_upd[60:0], 3'b000};
    fill   = {1'b0, idx_r, 2'b00} + {4'd0, nb};
    unique case (fill[1:0])
      2'd0:    mark = 32'h80000000;
      2'd1:    mark = 32'h00800000;
      2'd2:    mark = 32'h00008000;
      default: mark = 32'h00000080;
    endcase
    // Last block image: words past the last one cleared.
    for (int k = 0; k < 16; k++) begin
      lb[k] = (4'(k) < idx_r) ? buf_r[k] : 32'h0;
    end
    lb[idx_r] = in_msg_word & wmask;

    // Extra length-only block after a full-padding block. It carries the
    // marker when the message filled its last block.
    if (phase_r == PH_EXTRA && !cmd_valid_nxt) begin
      cmd_nxt.blk     = '0;
      cmd_nxt.blk[0]  = buf_r[0];
      cmd_nxt.blk[14] = bits_hold_hi;
      cmd_nxt.blk[15] = bits_hold_lo;
      cmd_nxt.fin     = 1'b1;
      cmd_valid_nxt   = 1'b1;
      phase_nxt       = PH_COLLECT;
      mbytes_nxt      = '0;
      idx_nxt         = '0;
    end else if (acc && !in_last_word) begin
      buf_nxt[idx_r] = in_msg_word;
      mbytes_nxt     = mbytes_r + 64'd4;
      idx_nxt        = idx_r + 4'd1;
      if (idx_r == 4'd15) begin
        cmd_nxt.blk   = buf_nxt;
        cmd_nxt.fin   = 1'b0;
        cmd_valid_nxt = 1'b1;
      end
    end else if (acc) begin
      mbytes_nxt  = mb_upd;
      cmd_nxt.fin = 1'b0;
      cmd_valid_nxt = 1'b1;
      if (fill == 7'd64) begin
        // Full block; padding and length go into a new block.
        cmd_nxt.blk = lb;
        buf_nxt     = '0;
        buf_nxt[0]  = 32'h80000000;
        phase_nxt   = PH_EXTRA;
      end else if (fill >= 7'd56) begin
        cmd_nxt.blk = lb;
        cmd_nxt.blk[fill[5:2]] = lb[fill[5:2]] | mark;
        buf_nxt     = '0;
        phase_nxt   = PH_EXTRA;
      end else begin
        cmd_nxt.blk = lb;
        cmd_nxt.blk[fill[5:2]] = lb[fill[5:2]] | mark;
        cmd_nxt.blk[14] = bits[63:32];
        cmd_nxt.blk[15] = bits[31:0];
        cmd_nxt.fin = 1'b1;
        mbytes_nxt  = '0;
        idx_nxt     = '0;
      end
    end
  end

  assign bits_hold_hi = bits_r[63:32];
  assign bits_hold_lo = bits_r[31:0];

  always_ff @(posedge clk) begin
    if (acc && in_last_word) begin
      bits_r <= bits;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COLLECT;
      idx_r       <= '0;
      mbytes_r    <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      mbytes_r    <= mbytes_nxt;
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    cmd_r <= cmd_nxt;
  end

endmodule

// File: design/sm3h_queue.sv
// ----------------------------------------------------------------------------
// SM3 block queue
// Two-entry queue of block commands between the front end and the engine.
// ----------------------------------------------------------------------------
module sm3h_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  sm3h_pkg::blk_cmd_t  wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sm3h_pkg::blk_cmd_t  rd_data
);
  import sm3h_pkg::*;

  blk_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// File: design/sm3h_engine.sv
// ----------------------------------------------------------------------------
// SM3 compression engine
// Runs 64 rounds per block, one per cycle, with the message expansion in a
// 16-word sliding window, then folds into the chaining value and streams out
// the digest after a final block.
// ----------------------------------------------------------------------------
module sm3h_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sm3h_pkg::blk_cmd_t  cmd,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_digest_index,
  output logic                out_digest_last
);
  import sm3h_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FOLD  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        st_r;
  logic [5:0]        rnd_r;
  logic              fin_r;
  logic [2:0]        oidx_r;
  logic [7:0][31:0]  cv_r;
  logic [7:0][31:0]  r_r;
  logic [15:0][31:0] w_r;

  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;

  assign cmd_ready        = st_r == ST_IDLE;
  assign out_empty        = st_r != ST_EMIT;
  assign out_digest_word  = cv_r[oidx_r];
  assign out_digest_index = oidx_r;
  assign out_digest_last  = oidx_r == 3'd7;

  // One round; the window holds W[j..j+15] with W[j] at position 0.
  always_comb begin
    tj  = rotl32((rnd_r < 6'd16) ? TJ_LO : TJ_HI, rnd_r[4:0]);
    a12 = rotl32(r_r[0], 5'd12);
    ss1 = rotl32(a12 + r_r[4] + tj, 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1  = ff + r_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2  = gg + r_r[7] + ss1 + w_r[0];
    wnew = perm1(w_r[0] ^ w_r[7] ^ rotl32(w_r[13], 5'd15))
           ^ rotl32(w_r[3], 5'd7) ^ w_r[10];
  end

  // Sequencer and chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      rnd_r  <= '0;
      fin_r  <= 1'b0;
      oidx_r <= '0;
      cv_r   <= {IV7, IV6, IV5, IV4, IV3, IV2, IV1, IV0};
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            st_r  <= ST_ROUND;
            rnd_r <= '0;
            fin_r <= cmd.fin;
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) st_r <= ST_FOLD;
        end
        ST_FOLD: begin
          cv_r   <= cv_r ^ r_r;
          oidx_r <= '0;
          st_r   <= fin_r ? ST_EMIT : ST_IDLE;
        end
        default: begin
          if (out_pop) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              st_r <= ST_IDLE;
              cv_r <= {IV7, IV6, IV5, IV4, IV3, IV2, IV1, IV0};
            end
          end
        end
      endcase
    end
  end

  // Working registers and expansion window.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && cmd_valid) begin
      w_r <= cmd.blk;
      r_r <= cv_r;
    end else if (st_r == ST_ROUND) begin
      r_r <= {r_r[6], rotl32(r_r[5], 5'd19), r_r[4], perm0(tt2),
              r_r[2], rotl32(r_r[1], 5'd9), r_r[0], tt1};
      w_r <= {wnew, w_r[15:1]};
    end
  end

endmodule

// File: design/sm3_hash_unit.sv
// ----------------------------------------------------------------------------
// SM3 hash unit
// Hashes a message of big-endian 32-bit words and returns the 256-bit digest
// as eight 32-bit words.
//
//   Channel  Ports                                      Handshake
//   input    in_msg_word, in_word_bytes, in_last_word   in_push / in_full
//   result   out_digest_word, out_digest_index,         out_pop / out_empty
//            out_digest_last
//
// A block of 16 words passes through load, 64 rounds and fold in the single
// shared round unit; words are taken at one per cycle while the two-entry
// block queue has room and no finished block waits to enter it.
// A final word adds one or two padded blocks before eight digest results.
// Reset (synchronous, rst_n low) loads the initial value and empties queues.
// Input stalls only while a block waits for the queue or padding is built.
// ----------------------------------------------------------------------------
module sm3_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_msg_word,
  input  logic [2:0]  in_word_bytes,
  input  logic        in_last_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_last
);
  import sm3h_pkg::*;

  logic     f_valid, f_ready, e_valid, e_ready;
  blk_cmd_t f_cmd, e_cmd;

  sm3h_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_msg_word, .in_word_bytes, .in_last_word,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  sm3h_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(e_valid), .rd_ready(e_ready), .rd_data(e_cmd)
  );

  sm3h_engine u_engine (
    .clk, .rst_n, .cmd_valid(e_valid), .cmd_ready(e_ready), .cmd(e_cmd),
    .out_empty, .out_pop, .out_digest_word, .out_digest_index, .out_digest_last
  );

endmodule
